[rtl/tbr_pkg.sv]
// ----------------------------------------------------------------------------
// tbr_pkg
// Shared types, constants and the arctangent table for the bearing/range unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tbr_pkg;

	localparam int CORDIC_STAGES_DEF = 20;
	localparam int COORD_W = 24;
	localparam int DIFF_W  = 25;
	localparam int PRE_W   = 26;   // pre-rotated x/y, may hold the negated difference
	localparam int GUARD   = 6;
	localparam int ACC_W   = 34;   // CORDIC x, y and angle accumulators
	localparam int RANGE_W = 25;
	localparam int BEAR_W  = 19;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_EMITTER_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_EMITTER_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_EMITTER_Z = 2'd2;

	localparam logic [29:0] GAIN_Q30          = 30'd652032874;
	localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic [RANGE_W-1:0] MAX_RANGE  = 25'd23726566;
	localparam logic signed [BEAR_W-1:0] MAX_BEARING = 19'sd205887;

	typedef enum logic [1:0] {
		ROT_NONE  = 2'd0,
		ROT_PLUS  = 2'd1,
		ROT_MINUS = 2'd2
	} rot_t;

	typedef struct packed {
		logic signed [PRE_W-1:0]  x;
		logic signed [PRE_W-1:0]  y;
		rot_t                     rot;
		logic                     zero;
		logic signed [DIFF_W-1:0] dz;
	} entry_t;

	// Truncated atan(2^-i) in Q30.
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd843314856;
			5'd1:  v = 32'd497837829;
			5'd2:  v = 32'd263043836;
			5'd3:  v = 32'd133525158;
			5'd4:  v = 32'd67021686;
			5'd5:  v = 32'd33543515;
			5'd6:  v = 32'd16775850;
			5'd7:  v = 32'd8388437;
			5'd8:  v = 32'd4194282;
			5'd9:  v = 32'd2097149;
			5'd10: v = 32'd1048575;
			5'd11: v = 32'd524287;
			5'd12: v = 32'd262143;
			5'd13: v = 32'd131071;
			5'd14: v = 32'd65535;
			5'd15: v = 32'd32767;
			5'd16: v = 32'd16383;
			5'd17: v = 32'd8191;
			5'd18: v = 32'd4095;
			5'd19: v = 32'd2047;
			5'd20: v = 32'd1023;
			5'd21: v = 32'd511;
			5'd22: v = 32'd255;
			5'd23: v = 32'd127;
			5'd24: v = 32'd63;
			5'd25: v = 32'd31;
			5'd26: v = 32'd15;
			5'd27: v = 32'd7;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/tbr_front.sv]
// ----------------------------------------------------------------------------
// tbr_front
// Emitter registers, coordinate differences and quadrant pre-rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module tbr_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [tbr_pkg::IDX_W-1:0]           cfg_index,
	input  wire logic [tbr_pkg::COORD_W-1:0]         cfg_data,
	input  wire logic signed [tbr_pkg::COORD_W-1:0]  point_x,
	input  wire logic signed [tbr_pkg::COORD_W-1:0]  point_y,
	input  wire logic signed [tbr_pkg::COORD_W-1:0]  point_z,
	output tbr_pkg::entry_t                          entry
);

	localparam int DIFF_W = tbr_pkg::DIFF_W;
	localparam int PRE_W  = tbr_pkg::PRE_W;

	logic signed [tbr_pkg::COORD_W-1:0] emit_x_q, emit_y_q, emit_z_q;
	logic signed [tbr_pkg::DIFF_W-1:0]  dx, dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_x_q <= '0;
			emit_y_q <= '0;
			emit_z_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tbr_pkg::REG_EMITTER_X: emit_x_q <= cfg_data;
				tbr_pkg::REG_EMITTER_Y: emit_y_q <= cfg_data;
				tbr_pkg::REG_EMITTER_Z: emit_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dx = DIFF_W'(point_x) - DIFF_W'(emit_x_q);
	assign dy = DIFF_W'(point_y) - DIFF_W'(emit_y_q);

	// Rotate the left half plane by a quarter turn so the CORDIC converges.
	always_comb begin
		entry.dz   = DIFF_W'(point_z) - DIFF_W'(emit_z_q);
		entry.zero = (dx == '0) && (dy == '0);
		if (!dx[DIFF_W-1]) begin
			entry.x   = PRE_W'(dx);
			entry.y   = PRE_W'(dy);
			entry.rot = tbr_pkg::ROT_NONE;
		end else if (!dy[DIFF_W-1]) begin
			entry.x   = PRE_W'(dy);
			entry.y   = -PRE_W'(dx);
			entry.rot = tbr_pkg::ROT_PLUS;
		end else begin
			entry.x   = -PRE_W'(dy);
			entry.y   = PRE_W'(dx);
			entry.rot = tbr_pkg::ROT_MINUS;
		end
	end

endmodule

`default_nettype wire

[rtl/tbr_queue.sv]
// ----------------------------------------------------------------------------
// tbr_queue
// Small register queue between the front and the CORDIC pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tbr_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire tbr_pkg::entry_t wr_entry,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output tbr_pkg::entry_t      rd_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tbr_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

[rtl/tbr_cordic.sv]
// ----------------------------------------------------------------------------
// tbr_cordic
// Unrolled vectoring CORDIC with gain compensation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbr_cordic #(
	parameter int CORDIC_STAGES = tbr_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire tbr_pkg::entry_t                    in_entry,
	output logic                                    in_pop,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [tbr_pkg::RANGE_W-1:0]             ground_range,
	output logic signed [tbr_pkg::DIFF_W-1:0]       height_offset,
	output logic signed [tbr_pkg::BEAR_W-1:0]       bearing
);

	localparam int N     = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int ACC_W = tbr_pkg::ACC_W;
	localparam int G     = tbr_pkg::GUARD;

	logic                               adv;
	logic                               valid_s [N+1];
	logic signed [ACC_W-1:0]            x_s [N+1];
	logic signed [ACC_W-1:0]            y_s [N+1];
	logic signed [ACC_W-1:0]            z_s [N+1];
	logic                               zero_s [N+1];
	logic signed [tbr_pkg::DIFF_W-1:0]  dz_s [N+1];

	logic                               valid_m_s, zero_m_s;
	logic [61:0]                        prod_m_s;
	logic signed [tbr_pkg::BEAR_W-1:0]  bear_m_s;
	logic signed [tbr_pkg::DIFF_W-1:0]  dz_m_s;
	logic signed [ACC_W-1:0]            z_round;
	logic signed [ACC_W-15:0]           z_shift;
	logic [31:0]                        x_clip;
	logic [62:0]                        prod_round;
	logic [26:0]                        range_raw;

	assign adv    = !out_valid || out_ready;
	assign in_pop = adv && in_valid;

	// Pipeline entry: guard bits and initial angle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]    <= ACC_W'(in_entry.x) <<< G;
			y_s[0]    <= ACC_W'(in_entry.y) <<< G;
			zero_s[0] <= in_entry.zero;
			dz_s[0]   <= in_entry.dz;
			case (in_entry.rot)
				tbr_pkg::ROT_PLUS:  z_s[0] <= tbr_pkg::HALF_PI_Q30;
				tbr_pkg::ROT_MINUS: z_s[0] <= -tbr_pkg::HALF_PI_Q30;
				default:            z_s[0] <= '0;
			endcase
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam logic signed [ACC_W-1:0] ATAN =
			ACC_W'(tbr_pkg::atan_q30(5'(g)));
		logic signed [ACC_W-1:0] xs, ys;

		assign xs = x_s[g] >>> g;
		assign ys = y_s[g] >>> g;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else if (adv) begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				zero_s[g+1] <= zero_s[g];
				dz_s[g+1]   <= dz_s[g];
				if (y_s[g] > 0) begin
					x_s[g+1] <= x_s[g] + ys;
					y_s[g+1] <= y_s[g] - xs;
					z_s[g+1] <= z_s[g] + ATAN;
				end else begin
					x_s[g+1] <= x_s[g] - ys;
					y_s[g+1] <= y_s[g] + xs;
					z_s[g+1] <= z_s[g] - ATAN;
				end
			end
		end
	end

	// Gain multiply and angle rounding.
	assign x_clip  = x_s[N][ACC_W-1] ? '0 : x_s[N][31:0];
	assign z_round = z_s[N] + ACC_W'(1 << 13);
	assign z_shift = z_round[ACC_W-1:14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_m_s <= 1'b0;
		end else if (adv) begin
			valid_m_s <= valid_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_m_s <= 62'(x_clip) * 62'(tbr_pkg::GAIN_Q30);
			zero_m_s <= zero_s[N];
			dz_m_s   <= dz_s[N];
			if (z_shift > (ACC_W-14)'(tbr_pkg::MAX_BEARING)) begin
				bear_m_s <= tbr_pkg::MAX_BEARING;
			end else if (z_shift < -(ACC_W-14)'(tbr_pkg::MAX_BEARING)) begin
				bear_m_s <= -tbr_pkg::MAX_BEARING;
			end else begin
				bear_m_s <= z_shift[tbr_pkg::BEAR_W-1:0];
			end
		end
	end

	assign prod_round = 63'(prod_m_s) + (63'(1) << 35);
	assign range_raw  = prod_round[62:36];

	// Output register; holds while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_m_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			height_offset <= dz_m_s;
			if (zero_m_s) begin
				ground_range <= '0;
				bearing      <= '0;
			end else begin
				ground_range <= (range_raw > 27'(tbr_pkg::MAX_RANGE)) ?
					tbr_pkg::MAX_RANGE : range_raw[tbr_pkg::RANGE_W-1:0];
				bearing      <= bear_m_s;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/target_bearing_and_range_unit.sv]
// ----------------------------------------------------------------------------
// target_bearing_and_range_unit
// Ground range, height offset and bearing from the emitter to a target point.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake                    Contents
//   s_axis     in         s_axis_tvalid/s_axis_tready  point_x, point_y, point_z
//   m_axis     out        m_axis_tvalid/m_axis_tready  ground_range, height_offset,
//                                                      bearing
//   cfg        in         cfg_wr_en                    emitter_pos_x/y/z
//
// One point is taken per cycle while the queue is not full. From an input
// transfer to the matching output transfer a point passes the queue path,
// the entry stage, the CORDIC micro-rotation stages, the gain multiply
// and the output register. Reset clears the emitter position to zero and
// empties every stage. A stall on the output freezes the CORDIC pipeline;
// the four-entry queue keeps taking points until it fills, then
// s_axis_tready falls.
`default_nettype none

module target_bearing_and_range_unit #(
	parameter int CORDIC_STAGES = tbr_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [tbr_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [tbr_pkg::COORD_W-1:0]  cfg_data,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// point_x [23:0], point_y [47:24], point_z [71:48]
	input  wire logic [71:0]                  s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// ground_range [24:0], height_offset [49:25], bearing [68:50], zero fill [71:69]
	output logic [71:0]                       m_axis_tdata
);

	tbr_pkg::entry_t front_entry, head_entry;
	logic            q_full, q_valid, q_pop, in_xfer;
	logic [tbr_pkg::RANGE_W-1:0]        ground_range;
	logic signed [tbr_pkg::DIFF_W-1:0]  height_offset;
	logic signed [tbr_pkg::BEAR_W-1:0]  bearing;

	assign s_axis_tready = !q_full;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Front: emitter registers, differences and quadrant classification.
	tbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.point_x   (s_axis_tdata[23:0]),
		.point_y   (s_axis_tdata[47:24]),
		.point_z   (s_axis_tdata[71:48]),
		.entry     (front_entry)
	);

	// Queue that decouples input acceptance from the CORDIC stall.
	tbr_queue #(
		.DEPTH (4)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_xfer),
		.wr_entry  (front_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rd_entry  (head_entry)
	);

	// Back: vectoring CORDIC, gain compensation and output register.
	tbr_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (q_valid),
		.in_entry      (head_entry),
		.in_pop        (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.ground_range  (ground_range),
		.height_offset (height_offset),
		.bearing       (bearing)
	);

	assign m_axis_tdata = {3'b000, bearing, height_offset, ground_range};

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the target bearing and range unit: points are
// streamed in under random back-pressure or none, each result is checked against an
// in-bench bit-exact CORDIC vectoring predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Holds the expected results in arrival order and compares each output transfer.
class range_bearing_board;
	logic [71:0] pending[$];
	int errors;
	int checked;

	function new();
		errors = 0;
		checked = 0;
	endfunction

	// Note the expected output word of one accepted point.
	function void note_point(logic [71:0] want);
		pending.push_back(want);
	endfunction

	// Compare one output transfer with the oldest expectation, field by field.
	function void check_result(logic [71:0] got);
		logic [71:0] want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		checked++;
		if (got[24:0] !== want[24:0]) begin
			$display("%0t: ground_range expected %0d actual %0d", $time, want[24:0], got[24:0]);
			errors++;
		end
		if (got[49:25] !== want[49:25]) begin
			$display("%0t: height_offset expected %0d actual %0d", $time,
				$signed(want[49:25]), $signed(got[49:25]));
			errors++;
		end
		if (got[68:50] !== want[68:50]) begin
			$display("%0t: bearing expected %0d actual %0d", $time,
				$signed(want[68:50]), $signed(got[68:50]));
			errors++;
		end
		if (got[71:69] !== want[71:69]) begin
			$display("%0t: fill bits expected %b actual %b", $time, want[71:69], got[71:69]);
			errors++;
		end
	endfunction
endclass

module tb;
	import tbr_pkg::*;

	localparam int STAGES = CORDIC_STAGES_DEF;
	localparam int LATENCY = STAGES + 4;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [71:0] m_axis_tdata;

	// The bench's own copy of the emitter position.
	logic signed [23:0] emit_x, emit_y, emit_z;

	int send_idle_pct;
	int recv_idle_pct;
	longint cycles = 0;
	int points_sent;
	range_bearing_board board;

	target_bearing_and_range_unit #(.CORDIC_STAGES(STAGES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Arithmetic shift right, rounding toward minus infinity.
	function automatic longint shift_floor(longint v, int s);
		return v >>> s;
	endfunction

	// Predict the output word for a point, given the current emitter position.
	// The math runs in 64-bit signed integers, wide enough for every stage.
	function automatic logic [71:0] predict_bearing_range(logic [23:0] px, logic [23:0] py,
			logic [23:0] pz);
		longint dx, dy, dz, x, y, z, xs, ys, range_v, bear_v;
		logic [71:0] word;
		dx = longint'($signed(px)) - longint'(emit_x);
		dy = longint'($signed(py)) - longint'(emit_y);
		dz = longint'($signed(pz)) - longint'(emit_z);
		range_v = 0;
		bear_v = 0;
		// Both differences zero is the tiny-magnitude guard: range and yaw stay zero.
		if (dx != 0 || dy != 0) begin
			// Quadrant pre-rotation brings the vector into the right half-plane.
			if (dx >= 0) begin
				x = dx; y = dy; z = 0;
			end else if (dy >= 0) begin
				x = dy; y = -dx; z = 64'sd1686629713;
			end else begin
				x = -dy; y = dx; z = -64'sd1686629713;
			end
			x = x * 64;
			y = y * 64;
			for (int i = 0; i < (STAGES > 32 ? 32 : STAGES); i++) begin
				xs = shift_floor(x, i);
				ys = shift_floor(y, i);
				if (y > 0) begin
					x += ys; y -= xs; z += longint'(atan_q30(i[4:0]));
				end else begin
					x -= ys; y += xs; z -= longint'(atan_q30(i[4:0]));
				end
			end
			if (x < 0)
				x = 0;
			// x stays below 2^33, so the product fits in 63 bits.
			range_v = (x * 64'sd652032874 + (64'sd1 <<< 35)) >>> 36;
			if (range_v > 23726566)
				range_v = 23726566;
			bear_v = shift_floor(z + 8192, 14);
			if (bear_v > 205887)
				bear_v = 205887;
			if (bear_v < -205887)
				bear_v = -205887;
		end
		word = '0;
		word[24:0] = range_v[24:0];
		word[49:25] = dz[24:0];
		word[68:50] = bear_v[18:0];
		return word;
	endfunction

	// Write one emitter register while the unit is idle.
	task automatic write_emitter(logic [IDX_W-1:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_EMITTER_X: emit_x = val;
			REG_EMITTER_Y: emit_y = val;
			REG_EMITTER_Z: emit_z = val;
			default: ;
		endcase
	endtask

	// Offer one point; the expectation is noted at the transfer edge.
	task automatic send_point(logic [23:0] px, logic [23:0] py, logic [23:0] pz);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pz, py, px};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_point(predict_bearing_range(px, py, pz));
		points_sent++;
	endtask

	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
	endtask

	// Hold off until every expected result has come, then let the pipe drain.
	task automatic drain();
		end_burst();
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(5))
			0: return 24'(24'h800000 + $urandom_range(3));
			1: return 24'(24'h7FFFFF - $urandom_range(3));
			2: return 24'($signed($urandom_range(8000)) - 4000);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_burst(int n);
		logic [23:0] px, py, pz;
		for (int k = 0; k < n; k++) begin
			px = rand_coord();
			py = rand_coord();
			pz = rand_coord();
			// Now and then put the target on an axis through the emitter.
			case ($urandom_range(9))
				0: px = emit_x;
				1: py = emit_y;
				2: begin px = emit_x; py = emit_y; end
				default: ;
			endcase
			send_point(px, py, pz);
		end
	endtask

	// Receiver side: random stalls and checking at each output transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata);
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		board = new();
		points_sent = 0;
		emit_x = '0; emit_y = '0; emit_z = '0;
		send_idle_pct = 10;
		recv_idle_pct = 56;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed points with the emitter at the origin: extremes, every axis
		// direction, the negative x axis and the coincident point.
		send_point(24'd0, 24'd0, 24'd0);
		send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		send_point(24'h800000, 24'h800000, 24'h800000);
		send_point(24'h800000, 24'd0, 24'd1);
		send_point(24'h800000, 24'h7FFFFF, 24'd0);
		send_point(24'h7FFFFF, 24'h800000, 24'd0);
		send_point(24'd4096, 24'd0, 24'hFFFFFF);
		send_point(24'd0, 24'd4096, 24'd0);
		send_point(24'd0, 24'hFFF000, 24'd0);
		send_point(24'hFFFFFF, 24'd0, 24'd0);
		send_point(24'hFFFFFF, 24'd1, 24'd0);
		send_point(24'hFFFFFF, 24'hFFFFFF, 24'd0);
		send_point(24'd1, 24'd1, 24'd0);
		drain();

		// Emitter at one corner, the first target at the far one: largest differences.
		write_emitter(REG_EMITTER_X, 24'h800000);
		write_emitter(REG_EMITTER_Y, 24'h7FFFFF);
		write_emitter(REG_EMITTER_Z, 24'h800000);
		send_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
		send_point(24'h800000, 24'h7FFFFF, 24'h800000);
		send_point(24'h7FFFFF, 24'h7FFFFF, 24'd0);
		send_point(24'h800000, 24'h800000, 24'd0);
		send_point(24'h000000, 24'h7FFFFF, 24'd0);
		random_burst(250);
		drain();

		send_idle_pct = 56;
		recv_idle_pct = 10;
		write_emitter(REG_EMITTER_X, 24'h7FFFFF);
		write_emitter(REG_EMITTER_Y, 24'h800000);
		write_emitter(REG_EMITTER_Z, 24'h7FFFFF);
		random_burst(250);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_emitter(REG_EMITTER_X, rand_coord());
		write_emitter(REG_EMITTER_Y, rand_coord());
		write_emitter(REG_EMITTER_Z, rand_coord());
		random_burst(330);
		drain();

		$display("Ran %0d points over four emitter positions, corners included,", points_sent);
		$display("%0d results compared under mixed and absent back-pressure.", board.checked);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
